/* rtl/rgb2yuv_pkg.sv */
// Shared constants, register indexes and color-space arithmetic for the RGB to NV12 converter.
package rgb2yuv_pkg;

    localparam int unsigned MAX_WIDTH_DEF  = 2048;
    localparam int unsigned MAX_HEIGHT_DEF = 4096;

    localparam int unsigned PIX_W   = 8;
    localparam int unsigned WIDTH_W  = 12;
    localparam int unsigned HEIGHT_W = 13;
    localparam int unsigned CFG_W    = 13;
    localparam int unsigned PSUM_W   = 9;
    localparam int unsigned ENTRY_W  = 2 * PSUM_W;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 12'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;

    typedef enum logic {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_index_t;

    typedef logic [PIX_W-1:0] pix_t;

    // Y = ((66R + 129G + 25B + 128) >> 8) + 16; the sum stays below 2^16
    function automatic pix_t calc_luma(input pix_t r, input pix_t g, input pix_t b);
        logic [15:0] acc;
        acc = 16'd66 * {8'd0, r} + 16'd129 * {8'd0, g} + 16'd25 * {8'd0, b} + 16'd128;
        return acc[15:8] + 8'd16;
    endfunction

    // Bias (128 << 8) + 128 keeps the sum positive; upper byte = rounded shift + 128
    function automatic pix_t calc_u(input pix_t r, input pix_t g, input pix_t b);
        logic [15:0] acc;
        acc = 16'd32896 + 16'd112 * {8'd0, b} - 16'd38 * {8'd0, r} - 16'd74 * {8'd0, g};
        return acc[15:8];
    endfunction

    function automatic pix_t calc_v(input pix_t r, input pix_t g, input pix_t b);
        logic [15:0] acc;
        acc = 16'd32896 + 16'd112 * {8'd0, r} - 16'd94 * {8'd0, g} - 16'd18 * {8'd0, b};
        return acc[15:8];
    endfunction

endpackage

/* rtl/rgb2yuv_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module rgb2yuv_ram #(
    parameter int unsigned WIDTH  = 18,
    parameter int unsigned DEPTH  = 1024,
    parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/rgb_to_yuv420_semiplanar.sv */
// RGB to YUV 4:2:0 semi-planar (NV12) converter, BT.601 studio range, with a chroma line store.
// Pipeline stages, in order: capture, convert, pair/line-store, output.
// Throughput: one pixel per clock unless m_tready stalls, set by the line store's 1R/1W ports.
// The even row's pair sums are written as an odd-column pixel leaves stage 3; the odd row
// reads the same entry one line later, so the line store needs no forwarding.
// Reset (aresetn low, synchronous): counters and stage valids clear, size returns to 640x480;
// the line store is not cleared and holds garbage until an even row writes it.
module rgb_to_yuv420_semiplanar #(
    parameter int unsigned MAX_WIDTH  = rgb2yuv_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT = rgb2yuv_pkg::MAX_HEIGHT_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration
    input  logic                            cfg_we,
    input  logic                            cfg_addr,
    input  logic [rgb2yuv_pkg::CFG_W-1:0]   cfg_wdata,
    // input pixels
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [23:0]                     s_tdata,   // red[7:0], green[15:8], blue[23:16]
    // output pixels
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [23:0]                     m_tdata,   // luma[7:0], chroma_u[15:8], chroma_v[23:16]
    output logic                            m_tuser,   // chroma_valid
    output logic                            m_tlast    // frame_end
);

    import rgb2yuv_pkg::*;

    localparam int unsigned COL_W  = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int unsigned ROW_W  = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
    localparam int unsigned DEPTH  = MAX_WIDTH / 2;
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned WC_W   = (WIDTH_W > COL_W + 1) ? WIDTH_W : COL_W + 1;
    localparam int unsigned HC_W   = (HEIGHT_W > ROW_W + 1) ? HEIGHT_W : ROW_W + 1;

    typedef struct packed {
        logic              col_odd;
        logic              row_odd;
        logic [ADDR_W-1:0] idx;
        logic              fend;
    } tag_t;

    // configuration
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [WC_W-1:0]     wc;
    logic [HC_W-1:0]     hc;
    logic [COL_W:0]      w_eff;
    logic [ROW_W:0]      h_eff;

    // position
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             col_last, row_last;
    logic             in_accept;
    tag_t             tag_in;

    // pipeline
    logic        v1_reg, v2_reg, v3_reg, v4_reg;
    logic        rdy1, rdy2, rdy3, rdy4;
    pix_t        s1_red_reg, s1_green_reg, s1_blue_reg;
    tag_t        s1_tag_reg, s2_tag_reg, s3_tag_reg;
    pix_t        s2_y_reg, s2_u_reg, s2_v_reg;
    pix_t        s3_y_reg, s3_u_reg, s3_v_reg;
    pix_t        pf_u_reg, pf_v_reg;
    logic [PSUM_W-1:0]  us, vs;
    logic [PSUM_W:0]    cu_sum, cv_sum;
    pix_t        out_luma_reg, out_u_reg, out_v_reg;
    logic        out_cvalid_reg, out_fend_reg;

    // line store
    logic               ram_we, ram_re;
    logic [ENTRY_W-1:0] ram_rdata;

    // ---------------- configuration ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (cfg_we) begin
            case (cfg_index_t'(cfg_addr))
                REG_IMAGE_WIDTH:  width_reg  <= cfg_wdata[WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // even sizes, clamped to 2..MAX
    always_comb begin
        wc = WC_W'({width_reg[WIDTH_W-1:1], 1'b0});
        if (wc < WC_W'(2)) begin
            wc = WC_W'(2);
        end else if (wc > WC_W'(MAX_WIDTH)) begin
            wc = WC_W'(MAX_WIDTH);
        end
        hc = HC_W'({height_reg[HEIGHT_W-1:1], 1'b0});
        if (hc < HC_W'(2)) begin
            hc = HC_W'(2);
        end else if (hc > HC_W'(MAX_HEIGHT)) begin
            hc = HC_W'(MAX_HEIGHT);
        end
        w_eff = wc[COL_W:0];
        h_eff = hc[ROW_W:0];
    end

    // ---------------- handshake ----------------
    assign rdy4     = !v4_reg || m_tready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;
    assign in_accept = s_tvalid && rdy1;

    // ---------------- position counters ----------------
    assign col_last = ({1'b0, col_reg} + (COL_W + 1)'(1)) >= w_eff;
    assign row_last = ({1'b0, row_reg} + (ROW_W + 1)'(1)) >= h_eff;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (in_accept) begin
            if (col_last) begin
                col_next = '0;
                row_next = row_last ? '0 : row_reg + ROW_W'(1);
            end else begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_comb begin
        tag_in.col_odd = col_reg[0];
        tag_in.row_odd = row_reg[0];
        tag_in.idx     = ADDR_W'(col_reg >> 1);
        tag_in.fend    = col_last && row_last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ---------------- stage valids ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // ---------------- stage 1: capture ----------------
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            s1_red_reg   <= s_tdata[7:0];
            s1_green_reg <= s_tdata[15:8];
            s1_blue_reg  <= s_tdata[23:16];
            s1_tag_reg   <= tag_in;
        end
    end

    // ---------------- stage 2: color conversion ----------------
    always_ff @(posedge aclk) begin
        if (v1_reg && rdy2) begin
            s2_y_reg   <= calc_luma(s1_red_reg, s1_green_reg, s1_blue_reg);
            s2_u_reg   <= calc_u(s1_red_reg, s1_green_reg, s1_blue_reg);
            s2_v_reg   <= calc_v(s1_red_reg, s1_green_reg, s1_blue_reg);
            s2_tag_reg <= s1_tag_reg;
        end
    end

    // odd-row, odd-column pixel fetches the even row's sums as it moves into stage 3
    assign ram_re = v2_reg && rdy3 && s2_tag_reg.col_odd && s2_tag_reg.row_odd;

    // ---------------- stage 3: pairing and line store ----------------
    always_ff @(posedge aclk) begin
        if (v2_reg && rdy3) begin
            s3_y_reg   <= s2_y_reg;
            s3_u_reg   <= s2_u_reg;
            s3_v_reg   <= s2_v_reg;
            s3_tag_reg <= s2_tag_reg;
        end
    end

    assign us     = {1'b0, pf_u_reg} + {1'b0, s3_u_reg};
    assign vs     = {1'b0, pf_v_reg} + {1'b0, s3_v_reg};
    assign cu_sum = {1'b0, us} + {1'b0, ram_rdata[ENTRY_W-1:PSUM_W]};
    assign cv_sum = {1'b0, vs} + {1'b0, ram_rdata[PSUM_W-1:0]};
    assign ram_we = v3_reg && rdy4 && s3_tag_reg.col_odd && !s3_tag_reg.row_odd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pf_u_reg <= '0;
            pf_v_reg <= '0;
        end else if (v3_reg && rdy4 && !s3_tag_reg.col_odd) begin
            pf_u_reg <= s3_u_reg;
            pf_v_reg <= s3_v_reg;
        end
    end

    rgb2yuv_ram #(
        .WIDTH  (ENTRY_W),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_line_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (s3_tag_reg.idx),
        .wdata ({us, vs}),
        .re    (ram_re),
        .raddr (s2_tag_reg.idx),
        .rdata (ram_rdata)
    );

    // ---------------- stage 4: output register ----------------
    always_ff @(posedge aclk) begin
        if (v3_reg && rdy4) begin
            out_luma_reg   <= s3_y_reg;
            out_fend_reg   <= s3_tag_reg.fend;
            out_cvalid_reg <= s3_tag_reg.col_odd && s3_tag_reg.row_odd;
            if (s3_tag_reg.col_odd && s3_tag_reg.row_odd) begin
                out_u_reg <= cu_sum[PSUM_W:2];
                out_v_reg <= cv_sum[PSUM_W:2];
            end else begin
                out_u_reg <= '0;
                out_v_reg <= '0;
            end
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = {out_v_reg, out_u_reg, out_luma_reg};
    assign m_tuser  = out_cvalid_reg;
    assign m_tlast  = out_fend_reg;

    // ---------------- assertions ----------------
    a_ram_no_collide: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && ram_re) |-> (s3_tag_reg.idx != s2_tag_reg.idx))
        else $error("line store read and write hit the same entry");

    a_chroma_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[23:8] == 16'd0))
        else $error("chroma fields nonzero without chroma_valid");

    a_luma_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:0] >= 8'd16 && m_tdata[7:0] <= 8'd235))
        else $error("luma out of studio range");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (!v1_reg && !v2_reg && !v3_reg && !v4_reg) |-> s_tready)
        else $error("input stalled with an empty pipeline");

endmodule

/* tb/tb_rgb_to_yuv420_semiplanar.sv */
// Self-checking testbench for the RGB to NV12 converter: pixel stream in, luma/chroma beats out.
`timescale 1ns / 1ps

module tb_rgb_to_yuv420_semiplanar;
    import rgb2yuv_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned SUM_SLOTS     = MAX_WIDTH_DEF / 2;
    localparam int unsigned RANDOM_PIXELS = 540;

    // {blue, green, red} per entry, same order as s_tdata
    localparam logic [23:0] DIRECTED_PIX [0:22] = '{
        24'h000000, 24'hFFFFFF, 24'h0000FF, 24'h00FF00, 24'hFF0000,
        24'hFFFF00, 24'hFF00FF, 24'h00FFFF, 24'hFFFF00, 24'h00FFFF,
        24'h808080,
        24'h00FFFF, 24'h00FFFF, 24'hFFFF00, 24'hFFFF00,
        24'hFF0000, 24'hFF0000, 24'hFF0000, 24'hFF0000,
        24'h0000FF, 24'h0000FF, 24'h0000FF, 24'h0000FF
    };

    typedef struct packed {
        logic [7:0] luma;
        logic       has_chroma;
        logic [7:0] chroma_u;
        logic [7:0] chroma_v;
        logic       frame_end;
    } nv12_beat_t;

    class nv12_scoreboard;
        logic [WIDTH_W-1:0]  width_reg;
        logic [HEIGHT_W-1:0] height_reg;
        int unsigned         col;
        int unsigned         row;
        int unsigned         first_u;
        int unsigned         first_v;
        logic [ENTRY_W-1:0]  pair_sums [SUM_SLOTS];
        bit                  sum_written [SUM_SLOTS];
        nv12_beat_t          expected_q [$];
        int                  errors;

        function new();
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            col        = 0;
            row        = 0;
            first_u    = 0;
            first_v    = 0;
            errors     = 0;
            foreach (sum_written[i]) sum_written[i] = 1'b0;
        endfunction

        function int unsigned clamp_size(int unsigned raw, int unsigned limit);
            int unsigned s;
            s = raw & ~32'd1;
            if (s < 2) s = 2;
            if (s > limit) s = limit;
            return s;
        endfunction

        function int unsigned line_len();
            return clamp_size(width_reg, MAX_WIDTH_DEF);
        endfunction

        function int unsigned frame_lines();
            return clamp_size(height_reg, MAX_HEIGHT_DEF);
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void set_reg(cfg_index_t idx, logic [CFG_W-1:0] value);
            case (idx)
                REG_IMAGE_WIDTH:  width_reg  = value[WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: height_reg = value[HEIGHT_W-1:0];
                default: ;
            endcase
        endfunction

        // an odd row must never read a pair slot that no even row has filled
        function bit width_safe(int unsigned raw);
            int unsigned n;
            if (row[0] == 1'b0) return 1'b1;
            n = clamp_size(raw & 32'hFFF, MAX_WIDTH_DEF) / 2;
            for (int unsigned i = 0; i < n; i++)
                if (!sum_written[i]) return 1'b0;
            return 1'b1;
        endfunction

        function int unsigned frame_remaining();
            int unsigned w;
            int unsigned h;
            int unsigned line_left;
            int unsigned rows_after;
            w = line_len();
            h = frame_lines();
            line_left  = (col + 1 >= w) ? 1 : w - col;
            rows_after = (row + 1 >= h) ? 0 : h - row - 1;
            return line_left + rows_after * w;
        endfunction

        function int unsigned frame_size();
            return line_len() * frame_lines();
        endfunction

        function void note_pixel(pix_t r, pix_t g, pix_t b);
            int          ri;
            int          gi;
            int          bi;
            int          yv;
            int          uv;
            int          vv;
            int unsigned slot;
            int unsigned su;
            int unsigned sv;
            nv12_beat_t  want;
            ri = int'(r);
            gi = int'(g);
            bi = int'(b);
            yv = ((66 * ri + 129 * gi + 25 * bi + 128) >>> 8) + 16;
            uv = (((-38 * ri - 74 * gi + 112 * bi + 128) >>> 8) + 128) & 255;
            vv = (((112 * ri - 94 * gi - 18 * bi + 128) >>> 8) + 128) & 255;
            want = '0;
            want.luma = yv[7:0];
            slot = (col >> 1) & (SUM_SLOTS - 1);
            if (col[0] == 1'b0) begin
                first_u = uv;
                first_v = vv;
            end else begin
                su = first_u + uv;
                sv = first_v + vv;
                if (row[0] == 1'b0) begin
                    pair_sums[slot]   = {su[8:0], sv[8:0]};
                    sum_written[slot] = 1'b1;
                end else begin
                    su = (su + pair_sums[slot][17:9]) >> 2;
                    sv = (sv + pair_sums[slot][8:0]) >> 2;
                    want.has_chroma = 1'b1;
                    want.chroma_u   = su[7:0];
                    want.chroma_v   = sv[7:0];
                end
            end
            if (col + 1 >= line_len()) begin
                col = 0;
                if (row + 1 >= frame_lines()) begin
                    row = 0;
                    want.frame_end = 1'b1;
                end else begin
                    row = row + 1;
                end
            end else begin
                col = col + 1;
            end
            expected_q.push_back(want);
        endfunction

        task report(input string what);
            $display("ERROR @%0t: %s", $realtime, what);
            errors++;
        endtask

        task check_result(input logic [23:0] data, input logic chroma_flag,
                          input logic last);
            nv12_beat_t want;
            if (expected_q.size() == 0) begin
                report("output beat with no pixel outstanding");
                return;
            end
            want = expected_q.pop_front();
            if (data[7:0] !== want.luma)
                report($sformatf("luma %0d, expected %0d", data[7:0], want.luma));
            if (chroma_flag !== want.has_chroma)
                report($sformatf("chroma_valid %b, expected %b", chroma_flag,
                                 want.has_chroma));
            if (data[15:8] !== want.chroma_u)
                report($sformatf("chroma_u %0d, expected %0d", data[15:8], want.chroma_u));
            if (data[23:16] !== want.chroma_v)
                report($sformatf("chroma_v %0d, expected %0d", data[23:16], want.chroma_v));
            if (last !== want.frame_end)
                report($sformatf("frame_end %b, expected %b", last, want.frame_end));
        endtask
    endclass

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             cfg_we    = 1'b0;
    logic             cfg_addr  = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [23:0]      s_tdata   = '0;   // red[7:0], green[15:8], blue[23:16]
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [23:0]      m_tdata;          // luma[7:0], chroma_u[15:8], chroma_v[23:16]
    logic             m_tuser;          // chroma_valid
    logic             m_tlast;          // frame_end

    nv12_scoreboard sb;
    bit             calm      = 1'b0;
    int unsigned    gap_odds  = 8;
    int unsigned    cycle_count = 0;

    rgb_to_yuv420_semiplanar dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("rgb_to_yuv420_semiplanar: mismatch");
            $finish;
        end
    end

    // input beats are noted before output beats are checked in the same edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_pixel(s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser, m_tlast);
        end
    end

    // receiver backpressure: ready runs, some long, broken by stalls; ready is held high throughout once calm is set
    initial begin
        int unsigned run;
        forever begin
            if (calm) begin
                @(negedge aclk) m_tready <= 1'b1;
            end else begin
                run = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(1, 25);
                repeat (run) @(negedge aclk) m_tready <= 1'b1;
                repeat ($urandom_range(1, 19)) @(negedge aclk) m_tready <= 1'b0;
            end
        end
    end

    function automatic pix_t pick_channel();
        if ($urandom_range(0, 4) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return pix_t'($urandom_range(0, 255));
    endfunction

    // leaves tvalid high; the caller lowers it after the last beat of a run
    task automatic send_pixel(input pix_t r, input pix_t g, input pix_t b);
        if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            repeat ($urandom_range(1, 19)) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                s_tdata  <= 24'($urandom());
            end
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {b, g, r};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_run(input int unsigned n);
        for (int unsigned i = 0; i < n; i++)
            send_pixel(pick_channel(), pick_channel(), pick_channel());
        @(negedge aclk) s_tvalid <= 1'b0;
    endtask

    task automatic send_directed(input int first, input int last);
        for (int i = first; i <= last; i++)
            send_pixel(DIRECTED_PIX[i][7:0], DIRECTED_PIX[i][15:8], DIRECTED_PIX[i][23:16]);
        @(negedge aclk) s_tvalid <= 1'b0;
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        sb.set_reg(idx, value);
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic settle();
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        int unsigned      random_count;
        int unsigned      raw_w;
        int unsigned      raw_h;
        int unsigned      n;
        logic [CFG_W-1:0] wval;

        sb = new();
        repeat (3) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // ten pixels of the first row at the reset width, then shrink to 4x2 mid-frame
        send_directed(0, 9);
        settle();
        write_reg(REG_IMAGE_WIDTH, 13'd5);
        write_reg(REG_IMAGE_HEIGHT, 13'd3);
        send_directed(10, 14);
        settle();
        // below-minimum sizes clamp to 2x2
        write_reg(REG_IMAGE_WIDTH, 13'd1);
        write_reg(REG_IMAGE_HEIGHT, 13'd0);
        send_directed(15, 22);
        settle();

        // tallest frame, cut short by a mid-frame height change
        write_reg(REG_IMAGE_WIDTH, 13'd3);
        write_reg(REG_IMAGE_HEIGHT, 13'h1FFF);
        send_run(20);
        settle();
        write_reg(REG_IMAGE_HEIGHT, 13'd12);
        send_run(sb.frame_remaining());

        random_count = 0;
        while (random_count < RANDOM_PIXELS) begin
            settle();
            calm = (random_count >= RANDOM_PIXELS * 3 / 4);
            case ($urandom_range(0, 2))
                0:       gap_odds = 0;
                1:       gap_odds = 3;
                default: gap_odds = 8;
            endcase
            raw_w = ($urandom_range(0, 7) == 0) ? $urandom_range(18, 130)
                                                : $urandom_range(0, 17);
            raw_h = $urandom_range(0, 9);
            if (!sb.width_safe(raw_w)) begin
                n = sb.frame_remaining();
                send_run(n);
                random_count += n;
                settle();
            end
            wval     = CFG_W'(raw_w);
            wval[12] = 1'($urandom_range(0, 1));   // above the width register, ignored
            case ($urandom_range(0, 3))
                0: write_reg(REG_IMAGE_WIDTH, wval);
                1: write_reg(REG_IMAGE_HEIGHT, CFG_W'(raw_h));
                2: begin
                    write_reg(REG_IMAGE_HEIGHT, CFG_W'(raw_h));
                    write_reg(REG_IMAGE_WIDTH, wval);
                end
                default: begin
                    write_reg(REG_IMAGE_WIDTH, wval);
                    write_reg(REG_IMAGE_HEIGHT, CFG_W'(raw_h));
                end
            endcase
            // a third of the runs stop at a random point in the frame, so the next write can land inside a frame
            if ($urandom_range(0, 2) == 0)
                n = $urandom_range(1, sb.frame_remaining());
            else
                n = sb.frame_remaining() + ($urandom_range(0, 1) ? sb.frame_size() : 0);
            send_run(n);
            random_count += n;
        end

        settle();
        if (sb.errors == 0) begin
            $display("rgb_to_yuv420_semiplanar: match");
        end else begin
            $display("rgb_to_yuv420_semiplanar: mismatch");
        end
        $finish;
    end

endmodule
